[rtl/selection_sort_engine_assert.svh]
// Assertion macros for the selection sort engine.
// Expects clk_i and rst_ni in the scope of every module that uses them.
`ifndef SELECTION_SORT_ENGINE_ASSERT_SVH
`define SELECTION_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sort engine assertion failed");

// Next-cycle implication, checked outside reset.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sort engine assertion failed");

`endif

[rtl/sse_pkg.sv]
// Shared types and constants of the selection sort engine.
// No dependencies; the front, back and top level refer to it by scoped names.
`default_nettype none

package sse_pkg;

  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned PADDR_BITS   = 3;
  localparam int unsigned PDATA_BITS   = 32;

  // Register byte addresses
  localparam logic [PADDR_BITS-1:0] ADDR_SIGNED_COMPARE = 3'd0;

  typedef struct packed {
    logic [DATA_BITS-1:0]    key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]    sorted_key;
    logic [PAYLOAD_BITS-1:0] sorted_payload;
    logic                    last_out;
    logic                    overflow;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/sse_queue.sv]
// Two-entry command queue between the front and the back of the sort engine.
// Generic over the entry type; no package needed.
`default_nettype none

module sse_queue #(
  parameter type entry_t = logic
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      data_o
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sse_front.sv]
// Front end of the sort engine: counts list slots and classifies each item.
// Depends on sse_pkg for the input item type.
`default_nettype none

module sse_front #(
  parameter int unsigned MAX_ELEMENTS = 32,
  parameter int unsigned KEY_BITS     = 32,
  parameter type         cmd_t        = logic
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire sse_pkg::in_item_t item_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic          full;

  assign full   = count_q == CW'(MAX_ELEMENTS);
  assign push_o = accept_i;

  always_comb begin
    cmd_o.key     = item_i.key[KEY_BITS-1:0];
    cmd_o.payload = item_i.payload;
    cmd_o.wr      = !full;
    cmd_o.close   = item_i.last_in;
    cmd_o.n       = full ? count_q : count_q + 1'b1;
    cmd_o.dropped = drop_q | full;
    count_d       = count_q;
    drop_d        = drop_q;
    if (accept_i) begin
      if (item_i.last_in) begin
        // list closed: start the next one empty
        count_d = '0;
        drop_d  = 1'b0;
      end else begin
        count_d = cmd_o.n;
        drop_d  = cmd_o.dropped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

endmodule

`default_nettype wire

[rtl/sse_back.sv]
// Back end of the sort engine: element memory, selection sort passes, emit.
// Depends on sse_pkg and selection_sort_engine_assert.svh.
`default_nettype none

module sse_back #(
  parameter int unsigned MAX_ELEMENTS = 32,
  parameter int unsigned KEY_BITS     = 32,
  parameter type         cmd_t        = logic
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        signed_compare_i,
  output logic             result_valid_o,
  output sse_pkg::out_item_t result_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned PW = sse_pkg::PAYLOAD_BITS;
  localparam int unsigned EW = KEY_BITS + PW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] iss_q, iss_d;
  logic          scan_last_q, scan_last_d;
  logic          rd_v_q, rd_v_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [KEY_BITS-1:0] best_key_q, best_key_d;
  logic [PW-1:0]       best_pay_q, best_pay_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic [KEY_BITS-1:0] topk_q, topk_d;
  logic [PW-1:0]       topp_q, topp_d;
  logic [AW-1:0] last_idx_q, last_idx_d;
  logic          ovf_q, ovf_d;
  logic          emit_v_q, emit_v_d;
  logic          emit_last_q, emit_last_d;

  logic [EW-1:0] mem [MAX_ELEMENTS];
  logic [EW-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd;

  logic [KEY_BITS-1:0] rd_key, flip;
  logic [PW-1:0]       rd_pay;
  logic [CW-1:0]       cmd_last;
  logic                take;

  assign rd_key   = rdata_q[EW-1 -: KEY_BITS];
  assign rd_pay   = rdata_q[PW-1:0];
  assign cmd_last = cmd_i.n - 1'b1;
  // signed order: flip the sign bit, then compare unsigned
  assign flip     = {signed_compare_i, {(KEY_BITS-1){1'b0}}};
  // first strictly greatest key wins; the first read of a pass seeds it
  assign take     = rd_v_q && ((rd_idx_q == '0) || ((rd_key ^ flip) > (best_key_q ^ flip)));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    iss_d       = iss_q;
    scan_last_d = scan_last_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    best_key_d  = take ? rd_key : best_key_q;
    best_pay_d  = take ? rd_pay : best_pay_q;
    best_idx_d  = take ? rd_idx_q : best_idx_q;
    topk_d      = topk_q;
    topp_d      = topp_q;
    last_idx_d  = last_idx_q;
    ovf_d       = ovf_q;
    emit_v_d    = 1'b0;
    emit_last_d = 1'b0;
    we          = 1'b0;
    wa          = top_q;
    wd          = {best_key_d, best_pay_d};
    re          = 1'b0;
    ra          = iss_q;
    cmd_pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.wr) begin
            we = 1'b1;
            wa = cmd_last[AW-1:0];
            wd = {cmd_i.key, cmd_i.payload};
          end
          if (cmd_i.close) begin
            last_idx_d  = cmd_last[AW-1:0];
            top_d       = cmd_last[AW-1:0];
            ovf_d       = cmd_i.dropped;
            iss_d       = '0;
            scan_last_d = 1'b0;
            state_d     = (cmd_last[AW-1:0] != '0) ? ST_SCAN : ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_last_q) begin
          re       = 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = iss_q;
          if (iss_q == top_q) begin
            scan_last_d = 1'b1;
          end else begin
            iss_d = iss_q + 1'b1;
          end
        end
        if (rd_v_q && (rd_idx_q == top_q)) begin
          // pass done: move the winner into the top slot
          we      = 1'b1;
          wa      = top_q;
          wd      = {best_key_d, best_pay_d};
          topk_d  = rd_key;
          topp_d  = rd_pay;
          state_d = ST_SWAP;
        end
      end
      ST_SWAP: begin
        we          = 1'b1;
        wa          = best_idx_q;
        wd          = {topk_q, topp_q};
        top_d       = top_q - 1'b1;
        iss_d       = '0;
        scan_last_d = 1'b0;
        state_d     = (top_q == AW'(1)) ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        re          = 1'b1;
        emit_v_d    = 1'b1;
        emit_last_d = iss_q == last_idx_q;
        if (iss_q == last_idx_q) begin
          state_d = ST_IDLE;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      iss_q       <= '0;
      scan_last_q <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_idx_q    <= '0;
      best_key_q  <= '0;
      best_pay_q  <= '0;
      best_idx_q  <= '0;
      topk_q      <= '0;
      topp_q      <= '0;
      last_idx_q  <= '0;
      ovf_q       <= 1'b0;
      emit_v_q    <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      iss_q       <= iss_d;
      scan_last_q <= scan_last_d;
      rd_v_q      <= rd_v_d;
      rd_idx_q    <= rd_idx_d;
      best_key_q  <= best_key_d;
      best_pay_q  <= best_pay_d;
      best_idx_q  <= best_idx_d;
      topk_q      <= topk_d;
      topp_q      <= topp_d;
      last_idx_q  <= last_idx_d;
      ovf_q       <= ovf_d;
      emit_v_q    <= emit_v_d;
      emit_last_q <= emit_last_d;
    end
  end

  assign result_valid_o          = emit_v_q;
  assign result_o.sorted_key     = sse_pkg::DATA_BITS'(rd_key);
  assign result_o.sorted_payload = rd_pay;
  assign result_o.last_out       = emit_last_q;
  assign result_o.overflow       = ovf_q;

`include "selection_sort_engine_assert.svh"

  `SSE_ASSERT_NEXT(a_last_ends_list, result_valid_o && result_o.last_out, !result_valid_o)
  `SSE_ASSERT_IMPLIES(a_swap_in_range, state_q == ST_SWAP, best_idx_q <= top_q)
  `SSE_ASSERT_IMPLIES(a_no_scan_while_emit, emit_v_q, !rd_v_q)

endmodule

`default_nettype wire

[rtl/selection_sort_engine.sv]
// Top level of the selection sort engine: register port, front, queue, back.
// Depends on sse_pkg, sse_front, sse_queue and sse_back.
//
//   channel   handshake                   payload
//   -------   -------------------------   ------------------------------------
//   input     start, busy                 item_i (key, payload, last_in)
//   result    result_valid_o (strobe)     result_o (sorted_key, sorted_payload,
//                                         last_out, overflow)
//   config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// Flow: the front takes one item per cycle while the two-entry queue has room;
// the back writes each element into its memory as it pops the command. A closing
// item of an N-element list starts a selection pass for each top from N-1 down
// to 1, the element memory's single read port setting the pace, then the emit
// of the N sorted elements in ascending key order.
// Reset clears control and working registers; the element memory holds no reset value.
// busy rises while the queue is full, i.e. while the back sorts or emits a list
// and two more items wait. Results leave as one-cycle strobes, never stalled.
`default_nettype none

module selection_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = 32,
  parameter int unsigned KEY_BITS     = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // item channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire sse_pkg::in_item_t                  item_i,
  // result channel
  output logic                                    result_valid_o,
  output sse_pkg::out_item_t                      result_o,
  // register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sse_pkg::PADDR_BITS-1:0]     paddr,
  input  wire logic [sse_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [sse_pkg::PDATA_BITS-1:0]          prdata,
  output logic                                    pready
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  // One command per accepted transaction, front to back.
  typedef struct packed {
    logic [KEY_BITS-1:0]              key;
    logic [sse_pkg::PAYLOAD_BITS-1:0] payload;
    logic                             wr;       // element kept in the store
    logic                             close;    // list ends: sort and emit
    logic [CW-1:0]                    n;        // elements kept so far
    logic                             dropped;  // list lost an element
  } cmd_t;

  logic signed_compare_q;
  logic accept;
  logic push, q_full, q_valid, pop;
  cmd_t push_cmd, pop_cmd;

  // Register port: always ready, one register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_compare_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == sse_pkg::ADDR_SIGNED_COMPARE)) begin
      signed_compare_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == sse_pkg::ADDR_SIGNED_COMPARE)
                  ? sse_pkg::PDATA_BITS'(signed_compare_q) : '0;

  // Hold off new transactions only while the queue cannot take one.
  assign busy   = q_full;
  assign accept = start && !busy;

  sse_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .KEY_BITS     (KEY_BITS),
    .cmd_t        (cmd_t)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  sse_queue #(
    .entry_t (cmd_t)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (pop_cmd)
  );

  sse_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .KEY_BITS     (KEY_BITS),
    .cmd_t        (cmd_t)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (pop_cmd),
    .cmd_pop_o        (pop),
    .signed_compare_i (signed_compare_q),
    .result_valid_o   (result_valid_o),
    .result_o         (result_o)
  );

endmodule

`default_nettype wire
